// ===== rtl/core/brre_pkg.sv =====
// ----------------------------------------------------------------------------
// brre_pkg
// Shared types and constants of the binarize row run extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package brre_pkg;

  localparam int unsigned MaxRuns   = 16;
  localparam int unsigned LabelBits = 11;
  localparam int unsigned CountBits = $clog2(MaxRuns);

  localparam int unsigned PixW   = 8;
  localparam int unsigned LabelW = 11;
  localparam int unsigned TotalW = 4;
  localparam int unsigned AddrW  = 5;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);

  localparam logic [PixW-1:0] ResetThreshold   = 8'd0;
  localparam logic [PixW-1:0] ResetWindowLeft  = 8'd0;
  localparam logic [PixW-1:0] ResetWindowRight = 8'd187;
  localparam logic [PixW-1:0] ResetNearRow     = 8'd119;
  localparam logic [PixW-1:0] ResetFarRow      = 8'd0;

  typedef enum logic [2:0] {
    CfgThreshold   = 3'd0,
    CfgWindowLeft  = 3'd1,
    CfgWindowRight = 3'd2,
    CfgNearRow     = 3'd3,
    CfgFarRow      = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KindRun     = 1'b0,
    KindSummary = 1'b1
  } kind_e;

  typedef struct packed {
    logic              kind;
    logic [PixW-1:0]   row;
    logic [PixW-1:0]   left;
    logic [PixW-1:0]   right;
    logic [LabelW-1:0] label;
    logic [TotalW-1:0] total;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/binarize_row_run_extract.sv =====
// ----------------------------------------------------------------------------
// binarize_row_run_extract
// Binarizes a raster pixel stream and reports horizontal white runs and
// per-row run counts.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (in_valid_i / in_ready_o) one per item.
// Each pixel updates the run tracking registers at the edge where it is
// accepted and its results, at most a run record and a row summary, are
// written into a four-entry result queue in the same edge. Results leave on
// the output channel (out_valid_o / out_ready_i) one per cycle while
// out_ready_i is high; a pixel's first result is visible once it is written
// and the results queued ahead of it have left. A pixel is accepted in every
// cycle while the queue has room for two results; a pixel that causes two
// results fills two queue entries, so a sustained stream of one pixel per
// cycle is kept unless row ends come faster than the queue drains. When the
// receiver stalls the queue fills and in_ready_o drops once fewer than two
// entries are free. Reset empties the queue, clears the run state and label
// counter and loads the register defaults. Registers are written through the
// APB port at byte address 4*i and read back there.
// ----------------------------------------------------------------------------
`default_nettype none

module binarize_row_run_extract (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [brre_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                gray_value_i,
  input  wire logic [7:0]                column_i,
  input  wire logic [7:0]                row_i,
  input  wire logic                      frame_start_i,
  input  wire logic                      row_end_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           kind_o,
  output logic [7:0]                     out_row_o,
  output logic [7:0]                     run_left_o,
  output logic [7:0]                     run_right_o,
  output logic [10:0]                    run_label_o,
  output logic [3:0]                     run_total_o,
  output logic                           last_o
);
  import brre_pkg::*;

  localparam logic [LabelBits-1:0] LabelMax = {LabelBits{1'b1}};

  logic [PixW-1:0] threshold_q, window_left_q, window_right_q, near_row_q, far_row_q;

  logic                 in_run_q, in_run_d;
  logic [PixW-1:0]      start_q, start_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 full_q, full_d;
  logic [LabelBits-1:0] label_q, label_d;

  result_t            fifo_q [FifoDepth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [PtrW:0]      fill_q, fill_d;

  logic cfg_wr, in_acc, out_acc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= ResetThreshold;
      window_left_q  <= ResetWindowLeft;
      window_right_q <= ResetWindowRight;
      near_row_q     <= ResetNearRow;
      far_row_q      <= ResetFarRow;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(paddr[4:2]))
        CfgThreshold:   threshold_q    <= pwdata[PixW-1:0];
        CfgWindowLeft:  window_left_q  <= pwdata[PixW-1:0];
        CfgWindowRight: window_right_q <= pwdata[PixW-1:0];
        CfgNearRow:     near_row_q     <= pwdata[PixW-1:0];
        CfgFarRow:      far_row_q      <= pwdata[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_e'(paddr[4:2]))
      CfgThreshold:   prdata = {24'd0, threshold_q};
      CfgWindowLeft:  prdata = {24'd0, window_left_q};
      CfgWindowRight: prdata = {24'd0, window_right_q};
      CfgNearRow:     prdata = {24'd0, near_row_q};
      CfgFarRow:      prdata = {24'd0, far_row_q};
      default:        prdata = 32'd0;
    endcase
  end

  logic                 in_run_e, full_e, row_ok, col_ok, hit;
  logic [CountBits-1:0] count_e, count_mid;
  logic [LabelBits-1:0] label_e;
  logic                 close_a, close_b, start_new, in_run_mid, full_mid, rec, summary;
  logic [PixW-1:0]      right_a, run_right;
  logic [TotalW-1:0]    total;
  result_t              rec_res, sum_res, res_a, res_b;
  logic [1:0]           push_n;

  always_comb begin
    // A frame start drops any open run before the pixel is handled.
    in_run_e = in_run_q && !frame_start_i;
    full_e   = full_q && !frame_start_i;
    count_e  = frame_start_i ? '0 : count_q;
    label_e  = frame_start_i ? '0 : label_q;

    row_ok = (row_i >= far_row_q) && (row_i <= near_row_q);
    col_ok = (column_i >= window_left_q) && (column_i <= window_right_q);
    hit    = row_ok && col_ok && (gray_value_i > threshold_q);

    close_a = in_run_e && !hit;
    right_a = (column_i > start_q) ? column_i - 8'd1 : start_q;

    start_new  = hit && !in_run_e && !full_e;
    in_run_mid = (in_run_e && hit) || start_new;
    start_d    = start_new ? column_i : start_q;
    close_b    = in_run_mid && ((column_i == window_right_q) || row_end_i);

    rec       = close_a || close_b;
    run_right = close_a ? right_a : column_i;
    label_d   = label_e + LabelBits'(rec && (label_e < LabelMax));
    count_mid = count_e + CountBits'(rec);
    full_mid  = full_e || (rec && (32'(count_mid) >= MaxRuns - 1));

    if (32'(count_mid) > 32'd15) begin
      total = 4'd15;
    end else begin
      total = TotalW'(count_mid);
    end

    summary = row_end_i && row_ok;

    in_run_d = !row_end_i && in_run_mid && !close_b;
    count_d  = row_end_i ? '0 : count_mid;
    full_d   = !row_end_i && full_mid;

    rec_res.kind  = KindRun;
    rec_res.row   = row_i;
    rec_res.left  = start_d;
    rec_res.right = run_right;
    rec_res.label = LabelW'(label_d);
    rec_res.total = '0;
    rec_res.last  = !summary;

    sum_res.kind  = KindSummary;
    sum_res.row   = row_i;
    sum_res.left  = '0;
    sum_res.right = '0;
    sum_res.label = '0;
    sum_res.total = total;
    sum_res.last  = 1'b1;

    res_a  = rec ? rec_res : sum_res;
    res_b  = sum_res;
    push_n = in_acc ? (2'(rec) + 2'(summary)) : 2'd0;
    fill_d = fill_q + (PtrW+1)'(push_n) - (PtrW+1)'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q <= 1'b0;
      start_q  <= '0;
      count_q  <= '0;
      full_q   <= 1'b0;
      label_q  <= '0;
    end else if (in_acc) begin
      in_run_q <= in_run_d;
      start_q  <= start_d;
      count_q  <= count_d;
      full_q   <= full_d;
      label_q  <= label_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_q + PtrW'(push_n);
      rd_q   <= rd_q + PtrW'(out_acc);
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_q] <= res_a;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_q + PtrW'(1)] <= res_b;
    end
  end

  assign in_ready_o  = (fill_q <= (PtrW+1)'(FifoDepth - 2));
  assign out_valid_o = (fill_q != '0);
  assign kind_o      = fifo_q[rd_q].kind;
  assign out_row_o   = fifo_q[rd_q].row;
  assign run_left_o  = fifo_q[rd_q].left;
  assign run_right_o = fifo_q[rd_q].right;
  assign run_label_o = fifo_q[rd_q].label;
  assign run_total_o = fifo_q[rd_q].total;
  assign last_o      = fifo_q[rd_q].last;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (PtrW+1)'(FifoDepth))
    else $error("result queue overflow");

  a_full_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> !in_run_q)
    else $error("run open while row is full");

  a_row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && row_end_i) |=> (!in_run_q && (count_q == '0) && !full_q))
    else $error("row state not cleared at row end");

  a_label_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !frame_start_i) |=> (label_q >= $past(label_q)))
    else $error("label counter went down without frame start");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MaxRuns - 1)
    else $error("row run count beyond limit");

endmodule

`default_nettype wire
